// File: rtl/ebc_pkg.sv
package ebc_pkg;

  // Datapath operation codes issued by the controller
  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_LOAD        = 4'd1;
  localparam logic [3:0] OP_INSERT      = 4'd2;
  localparam logic [3:0] OP_PURGE       = 4'd3;
  localparam logic [3:0] OP_SCAN_INIT   = 4'd4;
  localparam logic [3:0] OP_FIND        = 4'd5;
  localparam logic [3:0] OP_PICK        = 4'd6;
  localparam logic [3:0] OP_DAY_APPLY   = 4'd7;
  localparam logic [3:0] OP_DRAIN_APPLY = 4'd8;

  // Request command codes
  localparam logic CMD_DAY   = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [3:0] op;
    logic       out_load;
  } ebc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic store_empty;
  } ebc_sts_t;

endpackage

// File: rtl/ebc_ctrl.sv
module ebc_ctrl
  import ebc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     command,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ebc_sts_t sts,
  output ebc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_PURGE   = 4'd2;
  localparam logic [3:0] S_PICK    = 4'd3;
  localparam logic [3:0] S_APPLY   = 4'd4;
  localparam logic [3:0] S_DHEAD   = 4'd5;
  localparam logic [3:0] S_FIND    = 4'd6;
  localparam logic [3:0] S_DPICK   = 4'd7;
  localparam logic [3:0] S_DAPPLY  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = (command == CMD_DRAIN) ? S_DHEAD : S_INS;
        end
      end
      S_INS: begin
        cmd.op     = OP_INSERT;
        state_next = S_PURGE;
      end
      S_PURGE: begin
        cmd.op = OP_PURGE;
        if (sts.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.op     = OP_PICK;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.op     = OP_DAY_APPLY;
        state_next = S_OUT;
      end
      S_DHEAD: begin
        cmd.op     = OP_SCAN_INIT;
        state_next = sts.store_empty ? S_OUT : S_FIND;
      end
      S_FIND: begin
        cmd.op = OP_FIND;
        if (sts.scan_done) state_next = S_DPICK;
      end
      S_DPICK: begin
        cmd.op     = OP_PICK;
        state_next = S_DAPPLY;
      end
      S_DAPPLY: begin
        cmd.op     = OP_DRAIN_APPLY;
        state_next = S_DHEAD;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/ebc_dp.sv
module ebc_dp
  import ebc_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int COUNT_BITS = 16,
  parameter int LIFE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ebc_cmd_t    cmd,
  input  logic [15:0] arrival_count,
  input  logic [15:0] shelf_life,
  output ebc_sts_t    sts,
  output logic [31:0] eaten_now,
  output logic [31:0] eaten_total,
  output logic [31:0] current_day,
  output logic [6:0]  batches_held,
  output logic        overflow
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int NW  = $clog2(CAPACITY + 1);
  localparam int EXW = 33 + COUNT_BITS;
  localparam logic [32:0] MAX33 = 33'h0_FFFF_FFFF;

  // Batch store: {expiry, count}
  logic [EXW-1:0] mem [CAPACITY];
  logic [EXW-1:0] rd_data;
  logic           mem_we;
  logic [IW-1:0]  mem_wa;
  logic [IW-1:0]  mem_ra;
  logic [EXW-1:0] mem_wd;

  logic [31:0]           day, total, now;
  logic [NW-1:0]         nbat;
  logic                  ovf;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [LIFE_BITS-1:0]  life_in;
  logic [NW-1:0]         rd_idx, wr_idx;
  logic                  pend;
  logic [IW-1:0]         pidx;
  logic                  best_vld;
  logic [32:0]           best_exp;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IW-1:0]         best_idx;
  logic [COUNT_BITS-1:0] eat;

  logic [15:0]           cnt_m16, life_m16;
  logic [31:0]           cnt_w, life_w;
  logic [32:0]           e_exp;
  logic [COUNT_BITS-1:0] e_cnt;
  logic                  e_first;
  logic                  issue;
  logic [NW-1:0]         last;
  logic [32:0]           room;
  logic [32:0]           tot_sum, day_sum;

  // Field masking to the configured widths
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      cnt_m16[i]  = arrival_count[i] & (i < COUNT_BITS);
      life_m16[i] = shelf_life[i] & (i < LIFE_BITS);
    end
  end
  assign cnt_w  = 32'(cnt_m16);
  assign life_w = 32'(life_m16);

  assign e_exp   = rd_data[EXW-1:COUNT_BITS];
  assign e_cnt   = rd_data[COUNT_BITS-1:0];
  assign e_first = !best_vld || (e_exp < best_exp) ||
                   ((e_exp == best_exp) && (e_cnt < best_cnt));
  assign issue   = (rd_idx < nbat);
  assign last    = nbat - NW'(1);
  assign room    = best_exp - {1'b0, day};

  assign sts.scan_done   = !issue && !pend;
  assign sts.store_empty = (nbat == '0);

  // Saturating sums for the apply steps
  always_comb begin
    if (cmd.op == OP_DRAIN_APPLY) begin
      tot_sum = {1'b0, total} + 33'(eat);
      day_sum = {1'b0, day} + 33'(eat);
    end else begin
      tot_sum = {1'b0, total} + 33'd1;
      day_sum = {1'b0, day} + 33'd1;
    end
  end

  // Memory port drive
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    mem_ra = rd_idx[IW-1:0];
    case (cmd.op)
      OP_INSERT: begin
        mem_wa = nbat[IW-1:0];
        mem_wd = {33'({1'b0, day} + 33'(life_in)), cnt_in};
        mem_we = (cnt_in != '0) && (nbat < NW'(CAPACITY));
      end
      OP_PURGE: begin
        mem_wa = wr_idx[IW-1:0];
        mem_we = pend && (e_exp > {1'b0, day});
      end
      OP_PICK: begin
        mem_ra = last[IW-1:0];
      end
      OP_DAY_APPLY: begin
        mem_wa = best_idx;
        mem_we = best_vld;
        if (best_cnt != COUNT_BITS'(1)) mem_wd = {best_exp, best_cnt - COUNT_BITS'(1)};
      end
      OP_DRAIN_APPLY: begin
        mem_wa = best_idx;
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      day      <= '0;
      total    <= '0;
      nbat     <= '0;
      pend     <= 1'b0;
      best_vld <= 1'b0;
      rd_idx   <= '0;
      wr_idx   <= '0;
    end else begin
      case (cmd.op)
        OP_INSERT, OP_SCAN_INIT: begin
          if (cmd.op == OP_INSERT && mem_we) nbat <= nbat + NW'(1);
          rd_idx   <= '0;
          wr_idx   <= '0;
          pend     <= 1'b0;
          best_vld <= 1'b0;
        end
        OP_PURGE, OP_FIND: begin
          if (issue) rd_idx <= rd_idx + NW'(1);
          pend <= issue;
          if (pend && (cmd.op == OP_FIND || e_exp > {1'b0, day})) begin
            if (e_first) best_vld <= 1'b1;
            if (cmd.op == OP_PURGE) wr_idx <= wr_idx + NW'(1);
          end
          if (cmd.op == OP_PURGE && sts.scan_done) nbat <= wr_idx;
        end
        OP_DAY_APPLY: begin
          if (best_vld) begin
            total <= tot_sum[32] ? MAX33[31:0] : tot_sum[31:0];
            if (best_cnt == COUNT_BITS'(1)) nbat <= last;
          end
          day <= day_sum[32] ? MAX33[31:0] : day_sum[31:0];
        end
        OP_DRAIN_APPLY: begin
          total <= tot_sum[32] ? MAX33[31:0] : tot_sum[31:0];
          day   <= day_sum[32] ? MAX33[31:0] : day_sum[31:0];
          nbat  <= last;
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cnt_in  <= cnt_w[COUNT_BITS-1:0];
        life_in <= life_w[LIFE_BITS-1:0];
        now     <= '0;
        ovf     <= 1'b0;
      end
      OP_INSERT: begin
        if (cnt_in != '0 && !(nbat < NW'(CAPACITY))) ovf <= 1'b1;
      end
      OP_PURGE, OP_FIND: begin
        if (pend && (cmd.op == OP_FIND || e_exp > {1'b0, day}) && e_first) begin
          best_exp <= e_exp;
          best_cnt <= e_cnt;
          best_idx <= (cmd.op == OP_PURGE) ? wr_idx[IW-1:0] : pidx;
        end
        pidx <= rd_idx[IW-1:0];
      end
      OP_PICK: begin
        if (best_exp > {1'b0, day}) begin
          eat <= (33'(best_cnt) < room) ? best_cnt : room[COUNT_BITS-1:0];
        end else begin
          eat <= '0;
        end
      end
      OP_DAY_APPLY: begin
        if (best_vld) now <= 32'd1;
      end
      OP_DRAIN_APPLY: begin
        now <= now + 32'(eat);
      end
      default: begin
        now <= now;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      eaten_now    <= now;
      eaten_total  <= total;
      current_day  <= day;
      batches_held <= 7'(nbat);
      overflow     <= ovf;
    end
  end

endmodule

// File: rtl/expiring_batch_consumer.sv
// Channel | Handshake               | Payload
// in      | in_valid / in_stall     | command, arrival_count, shelf_life
// out     | out_valid / out_stall   | eaten_now, eaten_total, current_day,
//         |                         | batches_held, overflow
//
// A day request runs an insert, a compacting pass that purges expired batches
// and finds the earliest, pick, apply and publish. A drain request runs,
// per batch until the store is empty, a search pass over the batches left
// through the single read port, a pick and an apply; then it publishes.
// Synchronous active-high reset clears counters; the store needs no clearing.
// The next request is taken while a result waits under out_stall.
module expiring_batch_consumer
  import ebc_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int COUNT_BITS = 16,
  parameter int LIFE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] arrival_count,
  input  logic [15:0] shelf_life,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] eaten_now,
  output logic [31:0] eaten_total,
  output logic [31:0] current_day,
  output logic [6:0]  batches_held,
  output logic        overflow
);

  ebc_cmd_t cmd;
  ebc_sts_t sts;

  ebc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebc_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS),
    .LIFE_BITS  (LIFE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .arrival_count (arrival_count),
    .shelf_life    (shelf_life),
    .sts           (sts),
    .eaten_now     (eaten_now),
    .eaten_total   (eaten_total),
    .current_day   (current_day),
    .batches_held  (batches_held),
    .overflow      (overflow)
  );

`ifndef SYNTHESIS
  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // An accepted request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while busy");

  // A result is only published from the busy phase
  a_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> in_stall)
    else $error("result loaded while idle");
`endif

endmodule
